[rtl/pss_pkg.sv]
// Shared types and codes for the positional sequence store.
package pss_pkg;

  // Width of the 1-based position field of a request
  localparam int POS_W = 6;
  // Width of one stored element
  localparam int DATA_W = 32;

  // Request selector
  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_DISPLAY   = 3'd6
  } func_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // What a cell loads at the next edge
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_PREV,
    CMD_NEXT,
    CMD_HEAD
  } cell_cmd_t;

  // Sequencer state
  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_t;

endpackage

[rtl/pss_cell.sv]
// One storage cell of the chain: a register with a neighbor select.
module pss_cell
  import pss_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] load_data,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  input  logic [DATA_W-1:0] head_data,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;

  // Pick the source for this cell
  always_comb begin
    case (cmd)
      CMD_HOLD: data_next = data;
      CMD_LOAD: data_next = load_data;
      CMD_PREV: data_next = prev_data;
      CMD_NEXT: data_next = next_data;
      CMD_HEAD: data_next = head_data;
      default:  data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/positional_sequence_store_core.sv]
// Top level of the positional sequence store: control, chain of cells, result register.
//
// An ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// front in cell 0. Insert and delete requests shift the cells above the target
// position by one place, and each gives one result item; the next item is taken
// as soon as the result register is free. A display request walks the list by
// rotating the first count cells around the chain, one element per cycle while
// the result register is free. It accepts the request and then gives one result
// for each element; an empty list gives a single bare result. After the walk the
// cells are back in their original order. No input item is taken during a walk.
// Reset clears the element count, walk index, state and output valid; the cell
// contents need no clearing.
module positional_sequence_store_core
  import pss_pkg::*;
#(
  parameter int CAPACITY = 32,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  logic [DATA_W-1:0] value,
  input  logic [POS_W-1:0]  position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  count,
  output logic [DATA_W-1:0] element,
  output logic              element_valid,
  output logic              last
);

  // Compare width covering count + 1 and the position field
  localparam int CMP_W = ((CNT_W >= POS_W) ? CNT_W : POS_W) + 1;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  stored_count;
  logic [CNT_W-1:0]  stored_count_next;
  logic [CNT_W-1:0]  show_idx;
  logic [CNT_W-1:0]  show_idx_next;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              show_last;
  logic              full;
  logic              ins_pos_ok;
  logic              del_pos_ok;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [CMP_W-1:0]  sel_idx;
  logic              do_insert;
  logic              do_delete;
  logic              do_rotate;

  status_t           status_next;
  logic [DATA_W-1:0] element_next;
  logic              element_valid_next;
  logic              last_next;

  cell_cmd_t         cmd [CAPACITY];
  logic [DATA_W-1:0] cell_data [CAPACITY];

  // Handshake
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;

  // Request decode helpers
  assign pos_c      = CMP_W'(position);
  assign cnt_c      = CMP_W'(stored_count);
  assign full       = (stored_count == CNT_W'(CAPACITY));
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
  assign del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
  assign show_last  = (show_idx == stored_count - CNT_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (func == FN_DISPLAY) && (stored_count != '0)) begin
          state_next = S_SHOW;
        end
      end
      S_SHOW: begin
        if (out_free && show_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Request execution and result formation
  always_comb begin
    do_insert          = 1'b0;
    do_delete          = 1'b0;
    do_rotate          = 1'b0;
    sel_idx            = '0;
    load_out           = 1'b0;
    status_next        = ST_OK;
    element_next       = '0;
    element_valid_next = 1'b0;
    last_next          = 1'b1;
    stored_count_next  = stored_count;
    show_idx_next      = show_idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (func_t'(func))
            FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
              if (full) begin
                status_next = ST_FULL;
              end else if ((func == FN_INS_POS) && !ins_pos_ok) begin
                status_next = ST_INVALID;
              end else begin
                do_insert = 1'b1;
                if (func == FN_INS_BACK) begin
                  sel_idx = cnt_c;
                end else if (func == FN_INS_POS) begin
                  sel_idx = pos_c - CMP_W'(1);
                end
              end
            end
            FN_DEL_FRONT, FN_DEL_BACK: begin
              if (stored_count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                do_delete = 1'b1;
                if (func == FN_DEL_BACK) begin
                  sel_idx = cnt_c - CMP_W'(1);
                end
              end
            end
            FN_DEL_POS: begin
              if (!del_pos_ok) begin
                status_next = ST_INVALID;
              end else begin
                do_delete = 1'b1;
                sel_idx   = pos_c - CMP_W'(1);
              end
            end
            FN_DISPLAY: begin
              // Empty list gives a single bare result; otherwise start the walk
              if (stored_count != '0) begin
                load_out      = 1'b0;
                show_idx_next = '0;
              end
            end
            default: status_next = ST_INVALID;
          endcase
          if (do_insert) begin
            stored_count_next = stored_count + CNT_W'(1);
          end else if (do_delete) begin
            stored_count_next = stored_count - CNT_W'(1);
          end
        end
      end
      S_SHOW: begin
        if (out_free) begin
          load_out           = 1'b1;
          do_rotate          = 1'b1;
          element_next       = cell_data[0];
          element_valid_next = 1'b1;
          last_next          = show_last;
          show_idx_next      = show_idx + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Per-cell commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = CMD_HOLD;
      if (do_insert) begin
        if (CMP_W'(i) == sel_idx) begin
          cmd[i] = CMD_LOAD;
        end else if (CMP_W'(i) > sel_idx) begin
          cmd[i] = CMD_PREV;
        end
      end else if (do_delete) begin
        if (CMP_W'(i) >= sel_idx) begin
          cmd[i] = CMD_NEXT;
        end
      end else if (do_rotate) begin
        if (CMP_W'(i) == cnt_c - CMP_W'(1)) begin
          cmd[i] = CMD_HEAD;
        end else if (CMP_W'(i) < cnt_c - CMP_W'(1)) begin
          cmd[i] = CMD_NEXT;
        end
      end
    end
  end

  // Chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[g+1];
    end
    pss_cell u_cell (
      .clk       (clk),
      .cmd       (cmd[g]),
      .load_data (value),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      show_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      show_idx     <= show_idx_next;
      if (out_free) begin
        out_valid <= load_out;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= status_next;
      count         <= stored_count_next;
      element       <= element_next;
      element_valid <= element_valid_next;
      last          <= last_next;
    end
  end

  // Count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  // Count moves only when an item is taken
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(stored_count))
    else $error("stored count changed without an item");

  // A walk only runs over a non-empty list
  a_show_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> (stored_count != '0))
    else $error("display walk on empty list");

  // The walk ends with a last element result
  a_show_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && state_next == S_IDLE) |=> (out_valid && last && element_valid))
    else $error("display walk ended without last element");

endmodule
